### design/sat_alu_pkg.sv
`timescale 1ns / 1ps

package sat_alu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned WideW  = 64;
  localparam int unsigned OpW    = 3;
  localparam int unsigned NumCells = DataW;

  localparam logic [DataW-1:0] S32Max = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] S32Min = 32'h8000_0000;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_ABS   = 3'd4,
    OP_S64TO32 = 3'd5,
    OP_S32TO64 = 3'd6,
    OP_WORD  = 3'd7
  } op_e;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic             ovf;
  } sat_t;

  // one word in flight along the divider row
  typedef struct packed {
    op_e              op;
    logic [WideW-1:0] res;
    logic             ovf;
    logic             zf;
    logic             dz;
    logic             neg_q;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
  } cell_t;

  function automatic sat_t clamp33(input logic [DataW:0] v);
    sat_t s;
    s.ovf = v[DataW] ^ v[DataW-1];
    if (s.ovf) begin
      s.val = v[DataW] ? S32Min : S32Max;
    end else begin
      s.val = v[DataW-1:0];
    end
    return s;
  endfunction

  function automatic sat_t clamp64(input logic [WideW-1:0] v);
    sat_t s;
    s.ovf = (v[WideW-1:DataW-1] != {(WideW-DataW+1){v[WideW-1]}});
    if (s.ovf) begin
      s.val = v[WideW-1] ? S32Min : S32Max;
    end else begin
      s.val = v[DataW-1:0];
    end
    return s;
  endfunction

endpackage

### design/sat_alu_front.sv
`timescale 1ns / 1ps

module sat_alu_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [sat_alu_pkg::OpW-1:0]          operation_i,
  input  logic signed [sat_alu_pkg::WideW-1:0] operand_a_i,
  input  logic signed [sat_alu_pkg::DataW-1:0] operand_b_i,
  output logic                                 valid_o,
  output sat_alu_pkg::cell_t                   cell_o
);

  localparam int unsigned DW = sat_alu_pkg::DataW;
  localparam int unsigned WW = sat_alu_pkg::WideW;

  logic signed [DW-1:0] a_s;
  logic signed [DW-1:0] b_s;
  logic [DW:0]          sum_w;
  logic [DW:0]          diff_w;
  logic [DW:0]          abs_w;
  logic signed [WW-1:0] prod_s;
  logic [DW-1:0]        a_mag;
  logic [DW-1:0]        b_mag;
  sat_alu_pkg::sat_t    sat;
  sat_alu_pkg::op_e     op;
  sat_alu_pkg::cell_t   cell_d;
  sat_alu_pkg::cell_t   cell_q;
  logic                 valid_q;

  assign a_s    = operand_a_i[DW-1:0];
  assign b_s    = operand_b_i;
  assign op     = sat_alu_pkg::op_e'(operation_i);
  assign sum_w  = {a_s[DW-1], a_s} + {b_s[DW-1], b_s};
  assign diff_w = {a_s[DW-1], a_s} - {b_s[DW-1], b_s};
  assign abs_w  = a_s[DW-1] ? (~{a_s[DW-1], a_s} + {{DW{1'b0}}, 1'b1}) : {a_s[DW-1], a_s};
  assign prod_s = a_s * b_s;
  assign a_mag  = a_s[DW-1] ? (~a_s + {{(DW-1){1'b0}}, 1'b1}) : a_s;
  assign b_mag  = b_s[DW-1] ? (~b_s + {{(DW-1){1'b0}}, 1'b1}) : b_s;

  always_comb begin
    sat          = '0;
    cell_d       = '0;
    cell_d.op    = op;
    cell_d.neg_q = a_s[DW-1] ^ b_s[DW-1];
    cell_d.rem   = '0;
    cell_d.quo   = a_mag;
    cell_d.dvs   = b_mag;
    unique case (op)
      sat_alu_pkg::OP_ADD: begin
        sat        = sat_alu_pkg::clamp33(sum_w);
        cell_d.res = {{(WW-DW){sat.val[DW-1]}}, sat.val};
        cell_d.ovf = sat.ovf;
        cell_d.zf  = (sat.val == '0);
      end
      sat_alu_pkg::OP_SUB: begin
        sat        = sat_alu_pkg::clamp33(diff_w);
        cell_d.res = {{(WW-DW){sat.val[DW-1]}}, sat.val};
        cell_d.ovf = sat.ovf;
        cell_d.zf  = (sat.val == '0);
      end
      sat_alu_pkg::OP_MUL: begin
        cell_d.res = prod_s;
      end
      sat_alu_pkg::OP_DIV: begin
        if (b_s == '0) begin
          cell_d.dz  = 1'b1;
          cell_d.res = a_s[DW-1] ? {{(WW-1){1'b0}}, 1'b1} : {WW{1'b1}};
        end
      end
      sat_alu_pkg::OP_ABS: begin
        sat        = sat_alu_pkg::clamp33(abs_w);
        cell_d.res = {{(WW-DW){sat.val[DW-1]}}, sat.val};
        cell_d.ovf = sat.ovf;
        cell_d.zf  = !sat.ovf && (sat.val == '0);
      end
      sat_alu_pkg::OP_S64TO32: begin
        sat        = sat_alu_pkg::clamp64(operand_a_i);
        cell_d.res = {{(WW-DW){sat.val[DW-1]}}, sat.val};
        cell_d.ovf = sat.ovf;
        cell_d.zf  = (sat.val == '0);
      end
      sat_alu_pkg::OP_S32TO64: begin
        cell_d.res = {{(WW-DW){a_s[DW-1]}}, a_s};
      end
      sat_alu_pkg::OP_WORD: begin
        cell_d.res = {{(WW-16){1'b0}}, operand_a_i[15:0]};
      end
      default: begin
        cell_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

### design/sat_alu_cell.sv
`timescale 1ns / 1ps

module sat_alu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sat_alu_pkg::cell_t cell_i,
  output logic               valid_o,
  output sat_alu_pkg::cell_t cell_o
);

  localparam int unsigned DW = sat_alu_pkg::DataW;

  logic [DW:0]        shifted;
  logic [DW:0]        trial;
  logic               fits;
  sat_alu_pkg::cell_t cell_d;
  sat_alu_pkg::cell_t cell_q;
  logic               valid_q;

  // one restoring division step: one quotient bit per cell
  assign shifted = {cell_i.rem, cell_i.quo[DW-1]};
  assign trial   = shifted - {1'b0, cell_i.dvs};
  assign fits    = !trial[DW];

  always_comb begin
    cell_d     = cell_i;
    cell_d.rem = fits ? trial[DW-1:0] : shifted[DW-1:0];
    cell_d.quo = {cell_i.quo[DW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

### design/sat_alu_back.sv
`timescale 1ns / 1ps

module sat_alu_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  sat_alu_pkg::cell_t                   cell_i,
  output logic                                 done_o,
  output logic signed [sat_alu_pkg::WideW-1:0] result_o,
  output logic                                 overflow_o,
  output logic                                 zero_o,
  output logic                                 div_by_zero_o
);

  localparam int unsigned DW = sat_alu_pkg::DataW;
  localparam int unsigned WW = sat_alu_pkg::WideW;

  logic [DW:0]       neg_quo;
  sat_alu_pkg::sat_t sat;
  logic [WW-1:0]     res_d;
  logic              ovf_d;
  logic              zf_d;
  logic [WW-1:0]     res_q;
  logic              ovf_q;
  logic              zf_q;
  logic              dz_q;
  logic              done_q;

  assign neg_quo = ~{1'b0, cell_i.quo} + {{DW{1'b0}}, 1'b1};

  always_comb begin
    sat   = '0;
    res_d = cell_i.res;
    ovf_d = cell_i.ovf;
    zf_d  = cell_i.zf;
    if (cell_i.op == sat_alu_pkg::OP_MUL) begin
      sat   = sat_alu_pkg::clamp64(cell_i.res);
      res_d = {{(WW-DW){sat.val[DW-1]}}, sat.val};
      ovf_d = sat.ovf;
      zf_d  = (sat.val == '0);
    end else if (cell_i.op == sat_alu_pkg::OP_DIV && !cell_i.dz) begin
      if (cell_i.neg_q) begin
        sat = sat_alu_pkg::clamp33(neg_quo);
      end else begin
        sat = sat_alu_pkg::clamp33({1'b0, cell_i.quo});
      end
      res_d = {{(WW-DW){sat.val[DW-1]}}, sat.val};
      ovf_d = sat.ovf;
      zf_d  = (cell_i.quo == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ovf_q <= ovf_d;
    zf_q  <= zf_d;
    dz_q  <= cell_i.dz;
  end

  assign done_o        = done_q;
  assign result_o      = res_q;
  assign overflow_o    = ovf_q;
  assign zero_o        = zf_q;
  assign div_by_zero_o = dz_q;

endmodule

### design/saturating_signed_integer_alu.sv
`timescale 1ns / 1ps
// pipeline: one input stage, 32 divider cells giving one quotient bit each, one output stage
// throughput: one word per cycle, busy_o stays low and start_i may be high in every cycle
// the receiver cannot stall: each result is shown for exactly one cycle with done_o
// reset: rst_ni asynchronous, active low, clears every valid bit in the pipeline

module saturating_signed_integer_alu (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [sat_alu_pkg::OpW-1:0]          operation_i,
  input  logic signed [sat_alu_pkg::WideW-1:0] operand_a_i,
  input  logic signed [sat_alu_pkg::DataW-1:0] operand_b_i,
  output logic                                 done_o,
  output logic signed [sat_alu_pkg::WideW-1:0] result_o,
  output logic                                 overflow_o,
  output logic                                 zero_o,
  output logic                                 div_by_zero_o
);

  localparam int unsigned N = sat_alu_pkg::NumCells;

  logic               link_valid [N+1];
  sat_alu_pkg::cell_t link       [N+1];

  assign busy_o = 1'b0;

  sat_alu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (link_valid[0]),
    .cell_o      (link[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    sat_alu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[i]),
      .cell_i  (link[i]),
      .valid_o (link_valid[i+1]),
      .cell_o  (link[i+1])
    );
  end

  sat_alu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (link_valid[N]),
    .cell_i        (link[N]),
    .done_o        (done_o),
    .result_o      (result_o),
    .overflow_o    (overflow_o),
    .zero_o        (zero_o),
    .div_by_zero_o (div_by_zero_o)
  );

`ifndef SYNTHESIS
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_o) |-> (result_o == '0))
    else $error("zero flag with nonzero result");

  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |->
      (result_o == 64'sh0000_0000_7FFF_FFFF || result_o == 64'shFFFF_FFFF_8000_0000))
    else $error("overflow without saturated result");

  a_dz_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_by_zero_o) |->
      (!overflow_o && !zero_o && (result_o == 64'sd1 || result_o == -64'sd1)))
    else $error("divide by zero word malformed");
`endif

endmodule

### sim/saturating_signed_integer_alu_tb.sv
`timescale 1ns / 1ps

module saturating_signed_integer_alu_tb;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseWords  = 384;

  typedef struct {
    sat_alu_pkg::op_e op;
    logic [63:0]      a;
    logic [31:0]      b;
    int unsigned      idle_pct;
  } word_t;

  typedef struct packed {
    logic [63:0] result;
    logic        overflow;
    logic        zero;
    logic        div_by_zero;
  } alu_out_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           start_i       = 1'b0;
  logic                           busy_o;
  logic [sat_alu_pkg::OpW-1:0]    operation_i   = sat_alu_pkg::OP_ADD;
  logic signed [63:0]             operand_a_i   = '0;
  logic signed [31:0]             operand_b_i   = '0;
  logic                           done_o;
  logic signed [63:0]             result_o;
  logic                           overflow_o;
  logic                           zero_o;
  logic                           div_by_zero_o;

  word_t       pending_words[$];
  alu_out_t    results_due[$];
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;

  saturating_signed_integer_alu i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .done_o        (done_o),
    .result_o      (result_o),
    .overflow_o    (overflow_o),
    .zero_o        (zero_o),
    .div_by_zero_o (div_by_zero_o)
  );

  function automatic longint clip32(input longint v, output bit ovf);
    ovf = 1'b0;
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic alu_out_t saturated_alu(input sat_alu_pkg::op_e op,
                                             input logic [63:0] a_raw,
                                             input logic [31:0] b_raw);
    alu_out_t o;
    longint   a;
    longint   b;
    longint   r;
    bit       ovf;
    o   = '0;
    ovf = 1'b0;
    a   = longint'(signed'(a_raw[31:0]));
    b   = longint'(signed'(b_raw));
    case (op)
      sat_alu_pkg::OP_ADD: begin
        r = clip32(a + b, ovf);
        o.zero = (r == 0);
      end
      sat_alu_pkg::OP_SUB: begin
        r = clip32(a - b, ovf);
        o.zero = (r == 0);
      end
      sat_alu_pkg::OP_MUL: begin
        r = clip32(a * b, ovf);
        o.zero = (r == 0);
      end
      sat_alu_pkg::OP_DIV: begin
        if (b == 0) begin
          r = (a < 0) ? 64'sd1 : -64'sd1;
          o.div_by_zero = 1'b1;
        end else begin
          r = clip32(a / b, ovf);
          o.zero = (r == 0);
        end
      end
      sat_alu_pkg::OP_ABS: begin
        r = clip32((a < 0) ? -a : a, ovf);
        o.zero = !ovf && (r == 0);
      end
      sat_alu_pkg::OP_S64TO32: begin
        r = clip32(longint'(a_raw), ovf);
        o.zero = (r == 0);
      end
      sat_alu_pkg::OP_S32TO64: begin
        r = a;
      end
      default: begin
        r = longint'(a_raw[15:0]);
      end
    endcase
    o.result   = r;
    o.overflow = ovf;
    return o;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      5, 6: return 32'($urandom_range(200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_wide();
    logic [31:0] lo;
    lo = pick_operand();
    case ($urandom_range(4))
      0: return {$urandom, $urandom};
      1: return {{32{lo[31]}}, lo};
      2: return {32'h0, lo};
      3: return {32'hFFFF_FFFF, lo};
      default: return {32'($urandom_range(1)) - 32'd1, lo} ^ {32'($urandom_range(1)), 32'h0};
    endcase
  endfunction

  task automatic add_word(input sat_alu_pkg::op_e op, input logic [63:0] a,
                          input logic [31:0] b, input int unsigned idle);
    word_t w;
    w.op       = op;
    w.a        = a;
    w.b        = b;
    w.idle_pct = idle;
    pending_words.push_back(w);
  endtask

  task automatic add_random_word(input int unsigned idle);
    sat_alu_pkg::op_e op;
    logic [63:0]      a;
    logic [31:0]      b;
    op = sat_alu_pkg::op_e'($urandom_range(7));
    a  = (op == sat_alu_pkg::OP_S64TO32) ? pick_wide() : {$urandom, pick_operand()};
    b  = pick_operand();
    if (op == sat_alu_pkg::OP_DIV && $urandom_range(3) == 0) begin
      b = 32'($urandom_range(16)) - 32'd8;
    end
    add_word(op, a, b, idle);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      operation_i <= sat_alu_pkg::OP_ADD;
      operand_a_i <= '0;
      operand_b_i <= '0;
    end else begin : drive
      word_t nxt;
      if (start_i && !busy_o) begin
        results_due.push_back(saturated_alu(sat_alu_pkg::op_e'(operation_i),
                                            operand_a_i, operand_b_i));
      end
      if (!start_i || !busy_o) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= pending_words[0].idle_pct) begin
          nxt = pending_words.pop_front();
          start_i     <= 1'b1;
          operation_i <= nxt.op;
          operand_a_i <= nxt.a;
          operand_b_i <= nxt.b;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check
      alu_out_t due;
      if (results_due.size() == 0) begin
        $error("result word with none expected: result %h", result_o);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        if (result_o !== due.result) begin
          $error("result: expected %h, actual %h", due.result, result_o);
          mismatches++;
        end
        if (overflow_o !== due.overflow) begin
          $error("overflow: expected %b, actual %b", due.overflow, overflow_o);
          mismatches++;
        end
        if (zero_o !== due.zero) begin
          $error("zero: expected %b, actual %b", due.zero, zero_o);
          mismatches++;
        end
        if (div_by_zero_o !== due.div_by_zero) begin
          $error("div_by_zero: expected %b, actual %b", due.div_by_zero, div_by_zero_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned idle_by_phase[3];
    idle_by_phase = '{14, 69, 0};

    add_word(sat_alu_pkg::OP_ADD, 64'h0000_0000_7FFF_FFFF, 32'h0000_0001, 14);
    add_word(sat_alu_pkg::OP_ADD, 64'hFFFF_FFFF_8000_0000, 32'hFFFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_ADD, 64'hDEAD_BEEF_0000_0005, 32'hFFFF_FFFB, 14);
    add_word(sat_alu_pkg::OP_SUB, 64'h0000_0000_8000_0000, 32'h0000_0001, 14);
    add_word(sat_alu_pkg::OP_SUB, 64'h0000_0000_7FFF_FFFF, 32'hFFFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_SUB, 64'h1234_0000_0000_0007, 32'h0000_0007, 14);
    add_word(sat_alu_pkg::OP_MUL, 64'h0000_0000_7FFF_FFFF, 32'h7FFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_MUL, 64'h0000_0000_8000_0000, 32'h8000_0000, 14);
    add_word(sat_alu_pkg::OP_MUL, 64'h0000_0000_8000_0000, 32'hFFFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_MUL, 64'h0000_0000_FFFF_FFFD, 32'h0000_0007, 14);
    add_word(sat_alu_pkg::OP_DIV, 64'h0000_0000_0000_0007, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_DIV, 64'h0000_0000_FFFF_FFF9, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_DIV, 64'h0000_0000_0000_0000, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_DIV, 64'h0000_0000_8000_0000, 32'hFFFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_DIV, 64'h0000_0000_FFFF_FFF9, 32'h0000_0002, 14);
    add_word(sat_alu_pkg::OP_DIV, 64'h0000_0000_0000_0001, 32'h0000_0002, 14);
    add_word(sat_alu_pkg::OP_ABS, 64'h0000_0000_8000_0000, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_ABS, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_ABS, 64'h0000_0000_FFFF_FFFB, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_S64TO32, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_S64TO32, 64'h8000_0000_0000_0000, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_S64TO32, 64'h0000_0000_8000_0000, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_S64TO32, 64'h0000_0000_0000_0000, 32'h0000_0000, 14);
    add_word(sat_alu_pkg::OP_S32TO64, 64'h1234_5678_8000_0000, 32'h7FFF_FFFF, 14);
    add_word(sat_alu_pkg::OP_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 14);

    for (int p = 0; p < 3; p++) begin
      repeat (PhaseWords) add_random_word(idle_by_phase[p]);
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || start_i || results_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
